// ===== rtl/fsc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// File signature classifier package
// Shared widths, result type and the constant table of magic signatures.
// ----------------------------------------------------------------------------
package fsc_pkg;

   localparam int DATA_WIDTH    = 8;
   localparam int INDEX_WIDTH   = 6;
   localparam int ROM_ROWS      = 40;
   localparam int MAX_SIG_LEN   = 22;
   localparam int SIG_LEN_WIDTH = 5;
   localparam int SEL_WIDTH     = 5;

   typedef struct packed {
      logic                   matched;
      logic [INDEX_WIDTH-1:0] signature_index;
   } fsc_result_type;

   // Byte 0 of a signature sits in the top byte of sig_bytes. A set bit in
   // wild marks a position that matches any byte.
   typedef struct packed {
      logic [SIG_LEN_WIDTH-1:0]        sig_len;
      logic [MAX_SIG_LEN-1:0]          wild;
      logic [MAX_SIG_LEN*DATA_WIDTH-1:0] sig_bytes;
   } sig_entry_type;

   // The value holds exactly sig_len bytes; it is shifted up so that its
   // first byte lands in the top byte of the row.
   function automatic sig_entry_type make_sig(
      input logic [SIG_LEN_WIDTH-1:0]          sig_len,
      input logic [MAX_SIG_LEN-1:0]            wild,
      input logic [MAX_SIG_LEN*DATA_WIDTH-1:0] value
   );
      sig_entry_type entry;
      entry.sig_len   = sig_len;
      entry.wild      = wild;
      entry.sig_bytes = value << (DATA_WIDTH * (MAX_SIG_LEN - int'(sig_len)));
      return entry;
   endfunction

   localparam logic [MAX_SIG_LEN-1:0] NO_WILD   = '0;
   localparam logic [MAX_SIG_LEN-1:0] RIFF_WILD = 22'h0000F0;
   localparam logic [MAX_SIG_LEN-1:0] EXIF_WILD = 22'h000030;

   // Rows are in name order of the file types.
   localparam sig_entry_type SIG_ROM [ROM_ROWS] = '{
      make_sig(5'd12, RIFF_WILD, 176'h5249_4646_0000_0000_4156_4920),
      make_sig(5'd2,  NO_WILD,   176'h424D),
      make_sig(5'd4,  NO_WILD,   176'h4250_47FB),
      make_sig(5'd4,  NO_WILD,   176'hCAFE_BABE),
      make_sig(5'd22, NO_WILD,
               176'h0507_0000_424F_424F_0507_0000_0000_0000_0000_0000_0001),
      make_sig(5'd22, NO_WILD,
               176'h0607_E100_424F_424F_0607_E100_0000_0000_0000_0000_0001),
      make_sig(5'd7,  NO_WILD,   176'h21_3C61_7263_683E),
      make_sig(5'd7,  NO_WILD,   176'h78_0173_0D62_6260),
      make_sig(5'd2,  NO_WILD,   176'h4D5A),
      make_sig(5'd4,  NO_WILD,   176'h664C_6143),
      make_sig(5'd6,  NO_WILD,   176'h4749_4638_3761),
      make_sig(5'd6,  NO_WILD,   176'h4749_4638_3961),
      make_sig(5'd4,  NO_WILD,   176'h0001_0000),
      make_sig(5'd5,  NO_WILD,   176'h43_4430_3031),
      make_sig(5'd12, EXIF_WILD, 176'hFFD8_FFE1_0000_4578_6966_0000),
      make_sig(5'd12, NO_WILD,   176'hFFD8_FFE0_0010_4A46_4946_0001),
      make_sig(5'd4,  NO_WILD,   176'hFFD8_FFDB),
      make_sig(5'd4,  NO_WILD,   176'hFFD8_FFEE),
      make_sig(5'd4,  NO_WILD,   176'h4C5A_4950),
      make_sig(5'd3,  NO_WILD,   176'h49_4433),
      make_sig(5'd2,  NO_WILD,   176'hFFFB),
      make_sig(5'd4,  NO_WILD,   176'hA1B2_C3D4),
      make_sig(5'd4,  NO_WILD,   176'hD4C3_B2A1),
      make_sig(5'd5,  NO_WILD,   176'h25_5044_462D),
      make_sig(5'd8,  NO_WILD,   176'h8950_4E47_0D0A_1A0A),
      make_sig(5'd4,  NO_WILD,   176'h3842_5053),
      make_sig(5'd7,  NO_WILD,   176'h52_6172_211A_0700),
      make_sig(5'd8,  NO_WILD,   176'h5261_7221_1A07_0100),
      make_sig(5'd16, NO_WILD,   176'h5351_4C69_7465_2066_6F72_6D61_7420_3300),
      make_sig(5'd2,  NO_WILD,   176'h1FA0),
      make_sig(5'd2,  NO_WILD,   176'h1F9D),
      make_sig(5'd4,  NO_WILD,   176'h5444_4546),
      make_sig(5'd4,  NO_WILD,   176'h5444_4624),
      make_sig(5'd4,  NO_WILD,   176'h4D4D_002A),
      make_sig(5'd4,  NO_WILD,   176'h4949_2A00),
      make_sig(5'd4,  NO_WILD,   176'h0061_736D),
      make_sig(5'd12, RIFF_WILD, 176'h5249_4646_0000_0000_5741_5645),
      make_sig(5'd8,  NO_WILD,   176'h4443_4D01_5041_3330),
      make_sig(5'd6,  NO_WILD,   176'h3C3F_786D_6C20),
      make_sig(5'd16, NO_WILD,   176'h626F_6F6B_0000_0000_6D61_726B_0000_0000)
   };

endpackage
`default_nettype wire

// ===== rtl/fsc_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// File signature classifier channels
// Valid/ready channels for incoming file bytes and for classification results.
// ----------------------------------------------------------------------------
interface fsc_req_if;
   logic                          valid;
   logic                          ready;
   logic [fsc_pkg::DATA_WIDTH-1:0] data_byte;
   logic                          start_of_file;

   modport source (output valid, output data_byte, output start_of_file, input ready);
   modport sink   (input valid, input data_byte, input start_of_file, output ready);
endinterface

interface fsc_rsp_if;
   logic                           valid;
   logic                           ready;
   logic                           matched;
   logic [fsc_pkg::INDEX_WIDTH-1:0] signature_index;

   modport source (output valid, output matched, output signature_index, input ready);
   modport sink   (input valid, input matched, input signature_index, output ready);
endinterface
`default_nettype wire

// ===== rtl/fsc_match.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Signature byte compare
// Compares one file byte against every signature at the given position.
// ----------------------------------------------------------------------------
module fsc_match #(
   parameter int SIGNATURE_COUNT = 41,
   parameter int POS_WIDTH       = 6
) (
   input  wire logic [POS_WIDTH-1:0]            byte_pos,
   input  wire logic [fsc_pkg::DATA_WIDTH-1:0]  data_byte,
   output logic      [SIGNATURE_COUNT-1:0]      hit
);

   logic [fsc_pkg::SEL_WIDTH-1:0] sel;
   logic                          in_rom;

   always_comb begin
      in_rom = (byte_pos < POS_WIDTH'(fsc_pkg::MAX_SIG_LEN));
      sel    = in_rom ? byte_pos[fsc_pkg::SEL_WIDTH-1:0] : '0;
   end

   // A row keeps its slot alive when the position is past its length, the
   // position is a wildcard, or the byte equals the stored one.
   always_comb begin
      for (int r = 0; r < SIGNATURE_COUNT; r++) begin
         if (r < fsc_pkg::ROM_ROWS) begin
            hit[r] = !in_rom
               || (byte_pos >= POS_WIDTH'(fsc_pkg::SIG_ROM[r].sig_len))
               || fsc_pkg::SIG_ROM[r].wild[sel]
               || (fsc_pkg::SIG_ROM[r].sig_bytes[
                     fsc_pkg::DATA_WIDTH * (fsc_pkg::MAX_SIG_LEN - 1 - int'(sel)) +:
                     fsc_pkg::DATA_WIDTH] == data_byte);
         end else begin
            hit[r] = 1'b0;
         end
      end
   end

endmodule
`default_nettype wire

// ===== rtl/fsc_encode.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Surviving signature encoder
// Picks the lowest-numbered surviving signature and forms the result.
// ----------------------------------------------------------------------------
module fsc_encode #(
   parameter int SIGNATURE_COUNT = 41
) (
   input  wire logic [SIGNATURE_COUNT-1:0] alive,
   output fsc_pkg::fsc_result_type         result
);

   // Scanning downward lets the lowest set slot win.
   always_comb begin
      result = '0;
      for (int i = SIGNATURE_COUNT - 1; i >= 0; i--) begin
         if (alive[i]) begin
            result.matched         = 1'b1;
            result.signature_index = fsc_pkg::INDEX_WIDTH'(i);
         end
      end
   end

endmodule
`default_nettype wire

// ===== rtl/file_signature_classifier.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// File signature classifier
// Streams the first bytes of a file and reports which magic signature fits.
// ----------------------------------------------------------------------------
// The block takes one file byte per cycle with no gaps of its own. A byte
// marked as start of file restarts matching; without any marker after reset
// the first bytes count as the start of a file. Each byte is held in the
// input register, then the signature compare and the lowest-index pick
// run in one pass into the result register, which loads the result when
// the HEADER_BYTES-th byte leaves the input register. Bytes beyond the
// header are absorbed with no result until the next start of file. The
// only stall comes from a result beat that the sink has not yet taken
// while the final header byte of the next file waits behind it.
module file_signature_classifier #(
   parameter int HEADER_BYTES    = 32,
   parameter int SIGNATURE_COUNT = 41
) (
   input  wire logic  clock,
   input  wire logic  reset,
   fsc_req_if.sink    req_bus,
   fsc_rsp_if.source  rsp_bus
);

   localparam int PosWidth   = $clog2(HEADER_BYTES + 1);
   localparam int UsableRows = (SIGNATURE_COUNT < fsc_pkg::ROM_ROWS) ?
                               SIGNATURE_COUNT : fsc_pkg::ROM_ROWS;
   localparam logic [SIGNATURE_COUNT-1:0] UsableMask =
      {SIGNATURE_COUNT{1'b1}} >> (SIGNATURE_COUNT - UsableRows);

   logic                          in_vld_ff, in_vld_in;
   logic [fsc_pkg::DATA_WIDTH-1:0] in_byte_ff, in_byte_in;
   logic                          in_sof_ff, in_sof_in;
   logic [SIGNATURE_COUNT-1:0]    alive_ff, alive_in;
   logic [PosWidth-1:0]           pos_ff, pos_in;
   logic                          rsp_vld_ff, rsp_vld_in;
   fsc_pkg::fsc_result_type       rsp_res_ff, rsp_res_in;

   logic [PosWidth-1:0]           eff_pos;
   logic [SIGNATURE_COUNT-1:0]    eff_alive;
   logic [SIGNATURE_COUNT-1:0]    hit;
   logic [SIGNATURE_COUNT-1:0]    alive_next;
   fsc_pkg::fsc_result_type       enc_res;
   logic                          active;
   logic                          last;
   logic                          out_free;
   logic                          in_go;
   logic                          accept;

   fsc_match #(
      .SIGNATURE_COUNT (SIGNATURE_COUNT),
      .POS_WIDTH       (PosWidth)
   ) u_match (
      .byte_pos  (eff_pos),
      .data_byte (in_byte_ff),
      .hit       (hit)
   );

   fsc_encode #(
      .SIGNATURE_COUNT (SIGNATURE_COUNT)
   ) u_encode (
      .alive  (alive_next),
      .result (enc_res)
   );

   always_comb begin
      eff_pos    = in_sof_ff ? '0 : pos_ff;
      eff_alive  = in_sof_ff ? UsableMask : alive_ff;
      active     = (eff_pos < PosWidth'(HEADER_BYTES));
      last       = active && (eff_pos == PosWidth'(HEADER_BYTES - 1));
      alive_next = eff_alive & hit;

      out_free = !rsp_vld_ff || rsp_bus.ready;
      in_go    = in_vld_ff && (!last || out_free);
      req_bus.ready = !in_vld_ff || in_go;
      accept   = req_bus.valid && req_bus.ready;

      in_vld_in  = accept ? 1'b1 : (in_go ? 1'b0 : in_vld_ff);
      in_byte_in = accept ? req_bus.data_byte : in_byte_ff;
      in_sof_in  = accept ? req_bus.start_of_file : in_sof_ff;

      alive_in = alive_ff;
      pos_in   = pos_ff;
      if (in_go) begin
         alive_in = active ? alive_next : eff_alive;
         pos_in   = active ? eff_pos + PosWidth'(1) : eff_pos;
      end

      rsp_vld_in = rsp_vld_ff;
      rsp_res_in = rsp_res_ff;
      if (in_go && last) begin
         rsp_vld_in = 1'b1;
         rsp_res_in = enc_res;
      end else if (rsp_bus.ready) begin
         rsp_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         in_sof_ff  <= 1'b0;
         alive_ff   <= UsableMask;
         pos_ff     <= '0;
         rsp_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         in_sof_ff  <= in_sof_in;
         alive_ff   <= alive_in;
         pos_ff     <= pos_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
      rsp_res_ff <= rsp_res_in;
   end

   assign rsp_bus.valid           = rsp_vld_ff;
   assign rsp_bus.matched         = rsp_res_ff.matched;
   assign rsp_bus.signature_index = rsp_res_ff.signature_index;

   // The byte counter saturates at the header length.
   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= PosWidth'(HEADER_BYTES))
      else $error("byte position ran past the header length");

   // Slots without a signature can never come alive.
   a_unused_dead: assert property (@(posedge clock) disable iff (reset)
      (alive_ff & ~UsableMask) == '0)
      else $error("alive flag set for a slot without a signature");

   // A failed match always reports index zero.
   a_nomatch_index: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff && !rsp_res_ff.matched |-> rsp_res_ff.signature_index == '0)
      else $error("unmatched result carries a nonzero index");

   // The final header byte always produces a result beat.
   a_last_result: assert property (@(posedge clock) disable iff (reset)
      in_go && last |=> rsp_vld_ff)
      else $error("final header byte did not produce a result");

   // A byte never leaves the input register while its result has no room.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      in_go && last |-> out_free)
      else $error("result register overwritten before it was taken");

endmodule
`default_nettype wire
